@@ rtl/one_mismatch_pattern_search_assert.svh @@
// Assertion macros for the one-mismatch pattern search checker.
// Depends on nothing; included by the checker file.
`ifndef ONE_MISMATCH_PATTERN_SEARCH_ASSERT_SVH
`define ONE_MISMATCH_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication under an active-low reset
`define OMPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under an active-low reset
`define OMPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/omps_pkg.sv @@
// Shared types and constants of the one-mismatch pattern search.
// Used by the cell, the top level and the checker; depends on nothing.
package omps_pkg;

    localparam int SYM_W     = 8;
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 6;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 21;
    localparam int MCNT_W    = 2;
    localparam int SLOT_SPAN = 1 << IDX_W;

    localparam logic [MCNT_W-1:0] CNT_ZERO = 2'd0;
    localparam logic [MCNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [MCNT_W-1:0] CNT_SAT  = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_TEXT    = 2'd1,
        FUNC_RESTART = 2'd2
    } t_func;

    typedef struct packed {
        logic load;
        logic step;
        logic restart;
    } t_cell_ctl;

endpackage

@@ rtl/one_mismatch_pattern_search.sv @@
// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+---------------------------------------
// request   | i_in_valid   | o_in_stall   | i_func, i_symbol, i_pattern_index
// result    | o_out_valid  | i_out_stall  | o_start_position, o_mismatch_count
// config    | i_cfg_we     | (none)       | i_cfg_wdata (pattern length)
//
// One request per cycle while o_in_stall is low; a hit's result appears in the cycle after its text request.
// The first w_eff cells advance together; each after the first takes its neighbor's count.
// Reset is synchronous and active low; it clears counts and position and sets length 1.
// o_in_stall is high only while a result waits under i_out_stall.
// Top level of the one-mismatch pattern search; depends on omps_pkg and omps_cell.
module one_mismatch_pattern_search #(
    parameter int PAT_MAX  = 64,
    parameter int TEXT_MAX = 1048576
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [omps_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [omps_pkg::FUNC_W-1:0] i_func,
    input  logic [omps_pkg::SYM_W-1:0]  i_symbol,
    input  logic [omps_pkg::IDX_W-1:0]  i_pattern_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [omps_pkg::POS_W-1:0]  o_start_position,
    output logic                        o_mismatch_count
);

    localparam int LB = $clog2(PAT_MAX + 1);
    localparam int LW = (LB > omps_pkg::LEN_W) ? LB : omps_pkg::LEN_W;
    localparam int CW = $clog2(TEXT_MAX + 1);
    localparam int MW = (CW > LW) ? CW : LW;
    localparam int SW = ((MW > omps_pkg::POS_W) ? MW : omps_pkg::POS_W) + 1;

    logic [omps_pkg::LEN_W-1:0]  r_len;
    logic [CW-1:0]               r_tcnt;
    logic                        r_out_valid;
    logic [omps_pkg::POS_W-1:0]  r_start;
    logic                        r_mism;

    logic                        w_accept;
    logic                        w_load;
    logic                        w_text;
    logic                        w_restart;
    logic                        w_full;
    logic                        w_step;
    logic                        w_emit;
    logic [LW-1:0]               w_len_ext;
    logic [LW-1:0]               w_eff;
    logic [SW-1:0]               w_cnt_new;
    logic [SW-1:0]               w_eff_s;
    logic [SW-1:0]               w_start;
    logic [omps_pkg::MCNT_W-1:0] w_done;

    logic [omps_pkg::MCNT_W-1:0] w_cnt  [PAT_MAX];
    logic [omps_pkg::MCNT_W-1:0] w_next [PAT_MAX];
    logic [PAT_MAX-1:0]          w_last;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_load    = 1'b0;
        w_text    = 1'b0;
        w_restart = 1'b0;
        case (omps_pkg::t_func'(i_func))
            omps_pkg::FUNC_LOAD:    w_load    = w_accept;
            omps_pkg::FUNC_TEXT:    w_text    = w_accept;
            omps_pkg::FUNC_RESTART: w_restart = w_accept;
            default: ;
        endcase
    end

    assign w_full = (r_tcnt >= CW'(TEXT_MAX));
    assign w_step = w_text && !w_full;

    always_comb begin
        w_len_ext = LW'(r_len);
        if (w_len_ext == '0) begin
            w_eff = LW'(1);
        end else if (w_len_ext > LW'(PAT_MAX)) begin
            w_eff = LW'(PAT_MAX);
        end else begin
            w_eff = w_len_ext;
        end
    end

    for (genvar J = 0; J < PAT_MAX; J++) begin : g_cell
        omps_pkg::t_cell_ctl         w_ctl;
        logic [omps_pkg::MCNT_W-1:0] w_prev;
        logic                        w_sel;

        if (J < omps_pkg::SLOT_SPAN) begin : g_slot
            assign w_sel = (i_pattern_index == omps_pkg::IDX_W'(J));
        end else begin : g_noslot
            assign w_sel = 1'b0;
        end

        if (J == 0) begin : g_head
            assign w_prev = omps_pkg::CNT_ZERO;
        end else begin : g_link
            assign w_prev = w_cnt[J-1];
        end

        assign w_ctl.load    = w_load && w_sel;
        assign w_ctl.step    = w_step && (LW'(J) < w_eff);
        assign w_ctl.restart = w_restart;
        assign w_last[J]     = (LW'(J) == (w_eff - LW'(1)));

        omps_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_symbol   (i_symbol),
            .i_prev_cnt (w_prev),
            .o_cnt      (w_cnt[J]),
            .o_next_cnt (w_next[J])
        );
    end

    always_comb begin
        w_done = omps_pkg::CNT_ZERO;
        for (int k = 0; k < PAT_MAX; k++) begin
            w_done = w_done | (w_last[k] ? w_next[k] : omps_pkg::CNT_ZERO);
        end
    end

    assign w_cnt_new = SW'(r_tcnt) + SW'(1);
    assign w_eff_s   = SW'(w_eff);
    assign w_start   = w_cnt_new - w_eff_s + SW'(1);
    assign w_emit    = w_step && (w_cnt_new >= w_eff_s) && !w_done[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= omps_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcnt <= '0;
        end else if (w_restart) begin
            r_tcnt <= '0;
        end else if (w_step) begin
            r_tcnt <= r_tcnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_start <= w_start[omps_pkg::POS_W-1:0];
            r_mism  <= w_done[0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_start_position = r_start;
    assign o_mismatch_count = r_mism;

endmodule

@@ rtl/omps_cell.sv @@
// One alignment cell: holds a pattern byte and one open window's mismatch count.
// Depends on omps_pkg; chained by one_mismatch_pattern_search.
module omps_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  omps_pkg::t_cell_ctl         i_ctl,
    input  logic [omps_pkg::SYM_W-1:0]  i_symbol,
    input  logic [omps_pkg::MCNT_W-1:0] i_prev_cnt,
    output logic [omps_pkg::MCNT_W-1:0] o_cnt,
    output logic [omps_pkg::MCNT_W-1:0] o_next_cnt
);

    logic [omps_pkg::SYM_W-1:0]  r_pat;
    logic [omps_pkg::MCNT_W-1:0] r_cnt;
    logic [omps_pkg::MCNT_W-1:0] n_cnt;
    logic                        w_diff;

    assign w_diff = (r_pat != i_symbol);

    always_comb begin
        if (i_prev_cnt[1]) begin
            n_cnt = omps_pkg::CNT_SAT;
        end else begin
            n_cnt = i_prev_cnt + (w_diff ? omps_pkg::CNT_ONE : omps_pkg::CNT_ZERO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pat <= i_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= omps_pkg::CNT_ZERO;
        end else if (i_ctl.restart) begin
            r_cnt <= omps_pkg::CNT_ZERO;
        end else if (i_ctl.step) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt      = r_cnt;
    assign o_next_cnt = n_cnt;

endmodule

@@ rtl/omps_chk.sv @@
// Port-level checker for one_mismatch_pattern_search, attached by bind.
// Depends on omps_pkg and the assertion macro header.
`include "one_mismatch_pattern_search_assert.svh"

module omps_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [omps_pkg::FUNC_W-1:0] i_func,
    input logic                        o_out_valid,
    input logic                        i_out_stall
);

    `OMPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `OMPS_ASSERT_NOW(a_stall_src, i_clk, i_rst_n, 1'b1, o_in_stall == (o_out_valid && i_out_stall), "request stall not tied to a held result")
    `OMPS_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, o_out_valid && !i_out_stall && !(i_in_valid && !o_in_stall), !o_out_valid, "result repeated")
    `OMPS_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall && (i_func == omps_pkg::FUNC_TEXT)), "result without a text request")

endmodule

bind one_mismatch_pattern_search omps_chk u_omps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_func      (i_func),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

@@ test/tb_one_mismatch_pattern_search.sv @@
// Self-checking testbench for the one-mismatch pattern search top level.
// Depends on omps_pkg and one_mismatch_pattern_search; scores every text byte with
// its own window model and checks each reported hit field by field.
module tb_one_mismatch_pattern_search;

    localparam int PAT_MAX     = 64;
    localparam int TEXT_MAX    = 1048576;
    localparam int RAND_ITEMS  = 950;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 8;
    localparam logic [omps_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [omps_pkg::POS_W-1:0] start_position;
        logic                       mismatch_count;
    } t_hit;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_cfg_we        = 1'b0;
    logic [omps_pkg::LEN_W-1:0]  i_cfg_wdata     = '0;
    logic                        i_in_valid      = 1'b0;
    logic                        o_in_stall;
    logic [omps_pkg::FUNC_W-1:0] i_func          = '0;
    logic [omps_pkg::SYM_W-1:0]  i_symbol        = '0;
    logic [omps_pkg::IDX_W-1:0]  i_pattern_index = '0;
    logic                        o_out_valid;
    logic                        i_out_stall     = 1'b0;
    logic [omps_pkg::POS_W-1:0]  o_start_position;
    logic                        o_mismatch_count;

    logic [omps_pkg::SYM_W-1:0]  pattern_copy [PAT_MAX];
    logic [omps_pkg::MCNT_W-1:0] window_count [PAT_MAX];
    int unsigned                 text_taken;
    logic [omps_pkg::LEN_W-1:0]  length_reg;
    t_hit                        expected_hits [$];

    logic [omps_pkg::SYM_W-1:0]  motif [PAT_MAX];
    logic [omps_pkg::SYM_W-1:0]  alphabet [2];
    bit                          wide_symbols = 1'b1;
    bit                          send_gaps    = 1'b0;
    bit                          stall_gaps   = 1'b0;
    int                          stall_left   = 0;
    int                          rand_sent    = 0;
    int                          error_count  = 0;
    int                          cycle_count  = 0;

    one_mismatch_pattern_search #(
        .PAT_MAX  (PAT_MAX),
        .TEXT_MAX (TEXT_MAX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_symbol         (i_symbol),
        .i_pattern_index  (i_pattern_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_start_position (o_start_position),
        .o_mismatch_count (o_mismatch_count)
    );

    always #10 i_clk = ~i_clk;

    function automatic int used_length(logic [omps_pkg::LEN_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > PAT_MAX) return PAT_MAX;
        return int'(raw);
    endfunction

    function automatic logic [omps_pkg::MCNT_W-1:0] bump(logic [omps_pkg::MCNT_W-1:0] cnt,
                                                        bit differs);
        if (!differs) return cnt;
        return (cnt == omps_pkg::CNT_ZERO) ? omps_pkg::CNT_ONE : omps_pkg::CNT_SAT;
    endfunction

    function automatic void score_text_byte(logic [omps_pkg::SYM_W-1:0] sym);
        int                          len;
        logic [omps_pkg::MCNT_W-1:0] done;
        t_hit                        hit;
        if (text_taken >= TEXT_MAX) return;
        len = used_length(length_reg);
        done = (len >= 2) ? window_count[len-2] : omps_pkg::CNT_ZERO;
        done = bump(done, pattern_copy[len-1] != sym);
        for (int j = len - 1; j >= 1; j--)
            window_count[j] = bump(window_count[j-1], pattern_copy[j] != sym);
        window_count[0] = (pattern_copy[0] != sym) ? omps_pkg::CNT_ONE : omps_pkg::CNT_ZERO;
        text_taken++;
        if (text_taken >= len && done != omps_pkg::CNT_SAT) begin
            hit.start_position = omps_pkg::POS_W'(text_taken - len + 1);
            hit.mismatch_count = done[0];
            expected_hits = {expected_hits, hit};
        end
    endfunction

    function automatic logic [omps_pkg::SYM_W-1:0] pick_symbol();
        if (wide_symbols) return omps_pkg::SYM_W'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, 1)];
    endfunction

    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            window_count = '{default: omps_pkg::CNT_ZERO};
            text_taken = 0;
            length_reg = omps_pkg::LEN_W'(1);
        end else begin
            if (i_cfg_we)
                length_reg = i_cfg_wdata;
            if (i_in_valid && !o_in_stall) begin
                case (i_func)
                    omps_pkg::FUNC_LOAD: pattern_copy[i_pattern_index] = i_symbol;
                    omps_pkg::FUNC_TEXT: score_text_byte(i_symbol);
                    omps_pkg::FUNC_RESTART: begin
                        window_count = '{default: omps_pkg::CNT_ZERO};
                        text_taken = 0;
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result: start_position %0d mismatch_count %0d",
                           o_start_position, o_mismatch_count);
                    error_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (o_start_position !== want.start_position) begin
                        $error("start_position: expected %0d, actual %0d",
                               want.start_position, o_start_position);
                        error_count++;
                    end
                    if (o_mismatch_count !== want.mismatch_count) begin
                        $error("mismatch_count: expected %0d, actual %0d",
                               want.mismatch_count, o_mismatch_count);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[one_mismatch_pattern_search] ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else if (stall_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    task automatic send_request(logic [omps_pkg::FUNC_W-1:0] func,
                                logic [omps_pkg::SYM_W-1:0] sym,
                                logic [omps_pkg::IDX_W-1:0] slot);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 7)) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_func = func;
        i_symbol = sym;
        i_pattern_index = slot;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(logic [omps_pkg::LEN_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_symbol_extremes();
        send_request(omps_pkg::FUNC_LOAD, 8'h00, 6'd0);
        send_request(omps_pkg::FUNC_LOAD, 8'hFF, 6'd63);
        send_request(omps_pkg::FUNC_TEXT, 8'h00, 6'd63);
        send_request(omps_pkg::FUNC_TEXT, 8'hFF, 6'd0);
    endtask

    task automatic test_match_windows();
        send_gaps = 1'b1;
        stall_gaps = 1'b1;
        write_length(7'd4);
        send_request(omps_pkg::FUNC_LOAD, 8'h41, 6'd0);
        send_request(omps_pkg::FUNC_LOAD, 8'h42, 6'd1);
        send_request(omps_pkg::FUNC_LOAD, 8'h43, 6'd2);
        send_request(omps_pkg::FUNC_LOAD, 8'h44, 6'd3);
        send_request(omps_pkg::FUNC_RESTART, 8'h00, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h41, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h42, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h43, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h44, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h41, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h58, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h43, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h44, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h41, 6'd0);
        send_request(FUNC_NONE, 8'hFF, 6'd63);
        send_request(omps_pkg::FUNC_TEXT, 8'h42, 6'd0);
        send_request(omps_pkg::FUNC_RESTART, 8'hFF, 6'd63);
        send_request(omps_pkg::FUNC_TEXT, 8'h41, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h58, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h58, 6'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h44, 6'd0);
        write_length(7'd0);
        send_request(omps_pkg::FUNC_TEXT, 8'h41, 6'd0);
    endtask

    task automatic run_search_phase(bit gaps);
        int                         pick;
        int                         plen;
        int                         text_left;
        int                         errs;
        int                         pos1;
        int                         pos2;
        logic [omps_pkg::LEN_W-1:0] raw;
        logic [omps_pkg::SYM_W-1:0] sym;
        send_gaps = gaps;
        stall_gaps = gaps;
        pick = $urandom_range(0, 19);
        case (pick)
            0: raw = '0;
            1: raw = 7'd127;
            2: raw = 7'd64;
            3: raw = omps_pkg::LEN_W'($urandom_range(65, 126));
            4: raw = omps_pkg::LEN_W'($urandom_range(9, 63));
            default: raw = omps_pkg::LEN_W'($urandom_range(1, 8));
        endcase
        write_length(raw);
        plen = used_length(raw);
        wide_symbols = ($urandom_range(0, 3) == 0);
        alphabet[0] = omps_pkg::SYM_W'($urandom_range(0, 255));
        alphabet[1] = alphabet[0] ^ omps_pkg::SYM_W'($urandom_range(1, 255));
        for (int k = 0; k < plen; k++) begin
            motif[k] = pick_symbol();
            send_request(omps_pkg::FUNC_LOAD, motif[k], omps_pkg::IDX_W'(k));
            rand_sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
            send_request(omps_pkg::FUNC_RESTART, omps_pkg::SYM_W'($urandom),
                         omps_pkg::IDX_W'($urandom));
            rand_sent++;
        end
        text_left = $urandom_range(plen, 3 * plen + 20);
        while (text_left > 0) begin
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                send_request(FUNC_NONE, omps_pkg::SYM_W'($urandom),
                             omps_pkg::IDX_W'($urandom));
            end else if (pick == 1) begin
                pos1 = $urandom_range(0, plen - 1);
                motif[pos1] = pick_symbol();
                send_request(omps_pkg::FUNC_LOAD, motif[pos1], omps_pkg::IDX_W'(pos1));
                rand_sent++;
            end else if (pick == 2) begin
                send_request(omps_pkg::FUNC_RESTART, omps_pkg::SYM_W'($urandom),
                             omps_pkg::IDX_W'($urandom));
                rand_sent++;
            end else if (pick == 3) begin
                wait_drained();
            end else if (pick < 20) begin
                send_request(omps_pkg::FUNC_TEXT, pick_symbol(), omps_pkg::IDX_W'($urandom));
                rand_sent++;
                text_left--;
            end else begin
                errs = $urandom_range(0, 2);
                pos1 = $urandom_range(0, plen - 1);
                pos2 = $urandom_range(0, plen - 1);
                for (int k = 0; k < plen; k++) begin
                    sym = motif[k];
                    if ((errs >= 1 && k == pos1) || (errs >= 2 && k == pos2))
                        sym = sym ^ omps_pkg::SYM_W'($urandom_range(1, 255));
                    send_request(omps_pkg::FUNC_TEXT, sym, omps_pkg::IDX_W'($urandom));
                    rand_sent++;
                end
                text_left -= plen;
            end
        end
    endtask

    task automatic test_random_search();
        while (rand_sent < RAND_ITEMS * 4 / 5)
            run_search_phase($urandom_range(0, 3) != 0);
    endtask

    task automatic test_quiet_tail();
        while (rand_sent < RAND_ITEMS)
            run_search_phase(1'b0);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_symbol_extremes();
        test_match_windows();
        test_random_search();
        test_quiet_tail();
        wait_drained();
        if (error_count == 0)
            $display("[one_mismatch_pattern_search] OK");
        else
            $display("[one_mismatch_pattern_search] ERROR");
        $finish;
    end

endmodule
